/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the list block. Define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising edge outside reset.
`define CAL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define CAL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define CAL_ASSERT(label, clk, rst_n, prop, msg)
`define CAL_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* src/cal_pkg.sv */
// ---------------------------------------------------------------------------
// cal_pkg
// Command, status, state and result types of the cursor array list.
// ---------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

    // Command codes carried on the input beat.
    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_TAKE   = 3'd1,
        CMD_READ   = 3'd2,
        CMD_START  = 3'd3,
        CMD_END    = 3'd4,
        CMD_NEXT   = 3'd5,
        CMD_SET    = 3'd6,
        CMD_CLEAR  = 3'd7
    } t_cmd;

    // Status codes returned with every result beat.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_GET,
        S_DN,
        S_DONE
    } t_state;

    // One result beat.
    typedef struct packed {
        logic [31:0] data_out;
        t_status     status;
        logic [4:0]  item_count;
        logic [4:0]  cursor_now;
        logic        not_empty;
        logic        at_end;
    } t_result;

endpackage

`default_nettype wire

/* src/cal_ram.sv */
// ---------------------------------------------------------------------------
// cal_ram
// Element store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cal_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/cal_ctrl.sv */
// ---------------------------------------------------------------------------
// cal_ctrl
// Command sequencer: holds count and cursor and moves elements through the RAM.
// ---------------------------------------------------------------------------
`default_nettype none

module cal_ctrl
    import cal_pkg::*;
#(
    parameter int CAPACITY     = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [2:0]                  i_cmd,
    input  wire logic [31:0]                 i_data_in,
    input  wire logic [4:0]                  i_position,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output t_result                          o_res,
    output logic                             o_ram_we,
    output logic [$clog2(CAPACITY)-1:0]      o_ram_waddr,
    output logic [ELEMENT_BITS-1:0]          o_ram_wdata,
    output logic                             o_ram_re,
    output logic [$clog2(CAPACITY)-1:0]      o_ram_raddr,
    input  wire logic [ELEMENT_BITS-1:0]     i_ram_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ELEMENT_BITS + 32;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_cursor, n_cursor;
    logic [CW-1:0]           r_idx, n_idx;
    logic [ELEMENT_BITS-1:0] r_value, n_value;
    logic [ELEMENT_BITS-1:0] r_data, n_data;
    t_status                 r_status, n_status;
    logic                    r_take, n_take;

    logic                    w_accept;
    logic [XW-1:0]           w_in_ext;
    logic [XW-1:0]           w_out_ext;
    logic [CW-1:0]           w_cnt_m1;
    logic [CW-1:0]           w_cur_m1;
    logic [CW-1:0]           w_idx_m1;
    logic [CW-1:0]           w_idx_m2;
    logic [CW-1:0]           w_idx_p1;
    logic [CW-1:0]           w_idx_p2;

    // Element value fitted to the element width, and back to the result width.
    assign w_in_ext  = XW'(i_data_in);
    assign w_out_ext = XW'(r_data);

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cur_m1 = r_cursor - CW'(1);
    assign w_idx_m1 = r_idx - CW'(1);
    assign w_idx_m2 = r_idx - CW'(2);
    assign w_idx_p1 = r_idx + CW'(1);
    assign w_idx_p2 = r_idx + CW'(2);

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign w_accept    = i_valid && o_ready;

    // Result beat assembled from the settled state.
    always_comb begin
        o_res.data_out   = w_out_ext[31:0];
        o_res.status     = r_status;
        o_res.item_count = 5'(r_count);
        o_res.cursor_now = 5'(r_cursor);
        o_res.not_empty  = (r_count != '0);
        o_res.at_end     = (r_cursor == r_count);
    end

    // Next state, bookkeeping and RAM requests. During a shift the read address
    // stays two entries away from the write address, so no forwarding is needed.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_value  = r_value;
        n_data   = r_data;
        n_status = r_status;
        n_take   = r_take;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx[AW-1:0];
        o_ram_wdata = i_ram_rdata;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status = ST_OK;
                    n_data   = '0;
                    n_state  = S_DONE;
                    unique case (t_cmd'(i_cmd))
                        CMD_INSERT: begin
                            n_value = w_in_ext[ELEMENT_BITS-1:0];
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (r_cursor > r_count) begin
                                n_status = ST_RANGE;
                            end else if (r_cursor == r_count) begin
                                // Append: nothing to move.
                                o_ram_we    = 1'b1;
                                o_ram_waddr = r_cursor[AW-1:0];
                                o_ram_wdata = w_in_ext[ELEMENT_BITS-1:0];
                                n_cursor    = r_cursor + CW'(1);
                                n_count     = r_count + CW'(1);
                            end else begin
                                // Start moving the tail up from its last element.
                                o_ram_re    = 1'b1;
                                o_ram_raddr = w_cnt_m1[AW-1:0];
                                n_idx       = r_count;
                                n_state     = S_UP;
                            end
                        end
                        CMD_TAKE, CMD_READ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_cursor == '0 || r_cursor > r_count) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = w_cur_m1[AW-1:0];
                                n_take      = (t_cmd'(i_cmd) == CMD_TAKE);
                                n_state     = S_GET;
                            end
                        end
                        CMD_START: begin
                            n_cursor = (r_count == '0) ? '0 : CW'(1);
                        end
                        CMD_END: begin
                            n_cursor = r_count;
                        end
                        CMD_NEXT: begin
                            if (r_cursor < CW'(CAPACITY)) begin
                                n_cursor = r_cursor + CW'(1);
                            end
                        end
                        CMD_SET: begin
                            if (32'(i_position) > 32'(CAPACITY)) begin
                                n_cursor = CW'(CAPACITY);
                            end else begin
                                n_cursor = CW'(i_position);
                            end
                        end
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                    endcase
                end
            end

            S_UP: begin
                // Element read last cycle moves up by one entry.
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx[AW-1:0];
                o_ram_wdata = i_ram_rdata;
                if (w_idx_m1 == r_cursor) begin
                    n_state = S_PUT;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = w_idx_m2[AW-1:0];
                    n_idx       = w_idx_m1;
                end
            end

            S_PUT: begin
                // The gap at the cursor takes the new element.
                o_ram_we    = 1'b1;
                o_ram_waddr = r_cursor[AW-1:0];
                o_ram_wdata = r_value;
                n_cursor    = r_cursor + CW'(1);
                n_count     = r_count + CW'(1);
                n_state     = S_DONE;
            end

            S_GET: begin
                n_data = i_ram_rdata;
                if (!r_take) begin
                    n_state = S_DONE;
                end else if (r_cursor == r_count) begin
                    // Last element taken: nothing to move.
                    n_cursor = w_cur_m1;
                    n_count  = w_cnt_m1;
                    n_state  = S_DONE;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_cursor[AW-1:0];
                    n_idx       = w_cur_m1;
                    n_state     = S_DN;
                end
            end

            S_DN: begin
                // Element read last cycle moves down by one entry.
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx[AW-1:0];
                o_ram_wdata = i_ram_rdata;
                if (w_idx_p2 == r_count) begin
                    n_cursor = w_cur_m1;
                    n_count  = w_cnt_m1;
                    n_state  = S_DONE;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = w_idx_p2[AW-1:0];
                    n_idx       = w_idx_p1;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_data   <= n_data;
        r_status <= n_status;
        r_take   <= n_take;
    end

endmodule

`default_nettype wire

/* src/cursor_array_list.sv */
// ---------------------------------------------------------------------------
// cursor_array_list
// Fixed-capacity ordered list with a cursor, held in one synchronous RAM.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  command   i_valid / o_ready    i_cmd, i_data_in, i_position
//  result    o_valid / i_ready    o_data_out, o_status, o_item_count,
//                                 o_cursor_now, o_not_empty, o_at_end
//
//  One command is worked at a time. An insert or take that moves elements
//  shifts them one entry at a time, since the RAM moves one element per cycle.
//  A result waits in the output register; while that register holds a stalled
//  result beat, the next result waits in the sequencer, which then takes no
//  new command. Reset clears count and cursor; the RAM contents are not
//  cleared.
//
`default_nettype none
`include "assert_macros.svh"

module cursor_array_list
    import cal_pkg::*;
#(
    parameter int CAPACITY     = 16,
    parameter int ELEMENT_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_data_in,
    input  wire logic [4:0]  i_position,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_data_out,
    output logic [1:0]       o_status,
    output logic [4:0]       o_item_count,
    output logic [4:0]       o_cursor_now,
    output logic             o_not_empty,
    output logic             o_at_end
);

    localparam int AW = $clog2(CAPACITY);

    t_result                 w_res;
    logic                    w_res_valid;
    logic                    w_res_ready;
    logic                    w_ram_we;
    logic [AW-1:0]           w_ram_waddr;
    logic [ELEMENT_BITS-1:0] w_ram_wdata;
    logic                    w_ram_re;
    logic [AW-1:0]           w_ram_raddr;
    logic [ELEMENT_BITS-1:0] w_ram_rdata;

    t_result                 r_out;
    logic                    r_out_valid;

    // Sequencer.
    cal_ctrl #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_data_in   (i_data_in),
        .i_position  (i_position),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    // Element store.
    cal_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEMENT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register takes a result whenever it is empty or being drained.
    assign w_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_out   = r_out.data_out;
    assign o_status     = r_out.status;
    assign o_item_count = r_out.item_count;
    assign o_cursor_now = r_out.cursor_now;
    assign o_not_empty  = r_out.not_empty;
    assign o_at_end     = r_out.at_end;

    // An accepted command leaves the sequencer busy in the cycle after its beat.
    `CAL_ASSERT(a_busy_after_beat, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "command accepted on back-to-back cycles")

    // An empty-list error is only reported while the list holds nothing.
    `CAL_ASSERT(a_empty_status, i_clk, i_rst_n, (o_valid && o_status == ST_EMPTY) |-> !o_not_empty, "empty status with elements held")

    // Failed commands return no element data.
    `CAL_ASSERT_NEVER(a_err_data_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK && o_data_out != 32'd0, "data returned with an error status")

endmodule

`default_nettype wire
